@@ sv/rd_pkg.sv @@
// Shared types and constants of the restoring divider.
`timescale 1ns / 1ps

package rd_pkg;

    // Width of every operand and result field on the ports.
    localparam int FIELD_W = 8;

    // One operand pair.
    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_in;

    // One division result.
    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               div_by_zero;
    } t_out;

    // Control bits that travel alongside the data of each pipeline stage.
    typedef struct packed {
        logic valid;
        logic dz;
    } t_ctl;

endpackage

@@ sv/rd_round.sv @@
// One registered round of the restoring division pipeline.
`timescale 1ns / 1ps

module rd_round #(
    parameter int WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rd_pkg::t_ctl       i_ctl,
    input  logic [WIDTH-1:0]   i_acc,
    input  logic [WIDTH-1:0]   i_quo,
    input  logic [WIDTH-1:0]   i_dvs,
    output rd_pkg::t_ctl       o_ctl,
    output logic [WIDTH-1:0]   o_acc,
    output logic [WIDTH-1:0]   o_quo,
    output logic [WIDTH-1:0]   o_dvs
);

    rd_pkg::t_ctl     r_ctl;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] n_quo;

    // The partial remainder stays below the divisor, so its shifted value
    // minus the divisor always fits a WIDTH+1 bit two's complement word.
    always_comb begin
        shifted = {i_acc, i_quo[WIDTH-1]};
        diff    = shifted - {1'b0, i_dvs};
        if (diff[WIDTH]) begin
            n_acc = shifted[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b0};
        end else begin
            n_acc = diff[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_dvs <= i_dvs;
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule

@@ sv/restoring_divider.sv @@
// Top level of the pipelined unsigned restoring divider.
`timescale 1ns / 1ps

// Usage:
// An item (dividend and divisor) is taken at a rising clock edge where
// start is high and busy is low. Busy is low whenever reset is released,
// so one item can be taken in every cycle.
// Each item runs through an input register, WIDTH round stages (one
// shift and subtract per stage) and an output register. Its result sits
// on o_result for exactly one cycle, marked by o_strobe, when it leaves
// the output register. Results leave in the order items came in, one
// per item.
// Throughput is one item per clock; the pipeline holds WIDTH + 2 items
// in flight at most.
// A zero divisor raises div_by_zero and gives zero quotient and remainder.
// Operand bits above WIDTH are ignored; result bits above the 8-bit
// fields are dropped.
// A synchronous reset clears every valid bit, so items in flight are
// dropped and no strobe follows. Busy is high while reset is held.
// The receiver cannot stall, so the pipeline never holds back.
module restoring_divider #(
    parameter int WIDTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rd_pkg::t_in   i_item,
    output logic          o_strobe,
    output rd_pkg::t_out  o_result
);

    localparam int EXT_W = WIDTH + rd_pkg::FIELD_W;

    // Pipeline stage signals; stage 0 is the input register.
    rd_pkg::t_ctl     ctl_s [0:WIDTH];
    logic [WIDTH-1:0] acc_s [0:WIDTH];
    logic [WIDTH-1:0] quo_s [0:WIDTH];
    logic [WIDTH-1:0] dvs_s [0:WIDTH];

    rd_pkg::t_ctl     r_in_ctl;
    logic [WIDTH-1:0] r_in_dvd;
    logic [WIDTH-1:0] r_in_dvs;

    logic             r_out_valid;
    rd_pkg::t_out     r_out;

    logic             accept;
    logic [EXT_W-1:0] dvd_ext;
    logic [EXT_W-1:0] dvs_ext;
    logic [WIDTH-1:0] dvd_w;
    logic [WIDTH-1:0] dvs_w;
    logic [EXT_W-1:0] quo_ext;
    logic [EXT_W-1:0] rem_ext;
    rd_pkg::t_out     n_out;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // Fit the 8-bit fields to WIDTH bits: zero extend, then keep the low
    // WIDTH bits, which also masks off anything above WIDTH.
    assign dvd_ext = {{WIDTH{1'b0}}, i_item.dividend};
    assign dvs_ext = {{WIDTH{1'b0}}, i_item.divisor};
    assign dvd_w   = dvd_ext[WIDTH-1:0];
    assign dvs_w   = dvs_ext[WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else begin
            r_in_ctl.valid <= accept;
            r_in_ctl.dz    <= (dvs_w == '0);
        end
        r_in_dvd <= dvd_w;
        r_in_dvs <= dvs_w;
    end

    // The partial remainder starts at zero and the dividend register
    // doubles as the quotient register.
    assign ctl_s[0] = r_in_ctl;
    assign acc_s[0] = '0;
    assign quo_s[0] = r_in_dvd;
    assign dvs_s[0] = r_in_dvs;

    for (genvar k = 0; k < WIDTH; k++) begin : g_round
        rd_round #(
            .WIDTH (WIDTH)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_s[k]),
            .i_acc   (acc_s[k]),
            .i_quo   (quo_s[k]),
            .i_dvs   (dvs_s[k]),
            .o_ctl   (ctl_s[k+1]),
            .o_acc   (acc_s[k+1]),
            .o_quo   (quo_s[k+1]),
            .o_dvs   (dvs_s[k+1])
        );
    end

    // Fit the WIDTH-bit results back to the 8-bit fields. A zero divisor
    // still runs through the rounds, and its result is replaced here.
    assign quo_ext = {{rd_pkg::FIELD_W{1'b0}}, quo_s[WIDTH]};
    assign rem_ext = {{rd_pkg::FIELD_W{1'b0}}, acc_s[WIDTH]};

    always_comb begin
        if (ctl_s[WIDTH].dz) begin
            n_out.quotient  = '0;
            n_out.remainder = '0;
        end else begin
            n_out.quotient  = quo_ext[rd_pkg::FIELD_W-1:0];
            n_out.remainder = rem_ext[rd_pkg::FIELD_W-1:0];
        end
        n_out.div_by_zero = ctl_s[WIDTH].dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ctl_s[WIDTH].valid;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // An accepted item shows up in the input register on the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ctl_s[0].valid)
        else $error("accepted item did not enter the pipeline");

    // An item in the last round reaches the output register in the next cycle.
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_s[WIDTH].valid |=> o_strobe)
        else $error("finished item was not presented");

    // Nothing is presented unless the last round held an item.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(ctl_s[WIDTH].valid))
        else $error("strobe without an item in the last round");

    // A zero divisor yields zero quotient and remainder.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.div_by_zero) |->
            (o_result.quotient == '0 && o_result.remainder == '0))
        else $error("divide by zero result is not zero");

    // Reset leaves no strobe behind.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

endmodule
